FILE: design/riib_pkg.sv
// Package for the RGB integral image builder: sizes, register codes, line store and pipeline types.
package riib_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int NCH       = 3;
	localparam int PIX_W     = 8;
	localparam int PIX_SQ_W  = 2 * PIX_W;
	localparam int SUM_W     = 32;
	localparam int SQ_W      = 40;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// running row sums only ever span one row
	localparam int PIX_MAX = (1 << PIX_W) - 1;
	localparam int RS_W    = $clog2(MAX_WIDTH * PIX_MAX + 1);
	localparam int RSQ_W   = $clog2(MAX_WIDTH * PIX_MAX * PIX_MAX + 1);

	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT
	} cfg_reg_t;

	// one line store column: integrals of all three channels
	typedef struct packed {
		logic [NCH-1:0][SQ_W-1:0]  sq;
		logic [NCH-1:0][SUM_W-1:0] sum;
	} entry_t;

	typedef struct packed {
		logic [COL_W-1:0]          col;
		logic                      first_row;
		logic                      row_end;
		logic                      frame_end;
		logic                      fwd;
		logic [NCH-1:0][RS_W-1:0]  rs;
		logic [NCH-1:0][RSQ_W-1:0] rsq;
	} s1_t;

	typedef struct packed {
		entry_t data;
		logic   row_end;
		logic   frame_end;
	} result_t;

	// last index for a dimension register: 0 acts as 1, above max acts as max
	function automatic int unsigned last_index(logic [CFG_W-1:0] v, int unsigned maxv);
		int unsigned r;
		if (v == '0) begin
			r = 0;
		end else if (int'(v) > maxv) begin
			r = maxv - 1;
		end else begin
			r = int'(v) - 1;
		end
		return r;
	endfunction

endpackage

FILE: design/riib_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
module riib_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read during write to the same address returns the old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/rgb_integral_image_builder_unit.sv
// Top level of the RGB integral image builder: counters, row sums, line store pipeline, output.
//
//  channel | signals                                   | direction | transfer when
//  --------+-------------------------------------------+-----------+----------------------
//  pixel   | in_valid, in_ready, red, green, blue      | in        | in_valid & in_ready
//  result  | out_valid, out_ready, sum_*, square_sum_*,| out       | out_valid & out_ready
//          | row_end, frame_end                        |           |
//  config  | cfg_we, cfg_index, cfg_data               | in        | cfg_we
//
// One pixel per cycle sustained unless output stalls; path from pixel transfer to result valid
// (line store read in the accept cycle, add and write-back in stage 1, then the output register).
// The single line store port pair (one read, one write per cycle) sets the rate.
// Reset clears counters, row sums and valid flags; the line store is not cleared, the first row
// of each frame ignores it. Registers reset to 640 x 480.
// An output stall holds stage 1; a new pixel is still taken while the result register is full
// as long as stage 1 is free or moves on in that cycle.
module rgb_integral_image_builder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [riib_pkg::PIX_W-1:0]      red,
	input  logic [riib_pkg::PIX_W-1:0]      green,
	input  logic [riib_pkg::PIX_W-1:0]      blue,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [riib_pkg::SUM_W-1:0]      sum_red,
	output logic [riib_pkg::SUM_W-1:0]      sum_green,
	output logic [riib_pkg::SUM_W-1:0]      sum_blue,
	output logic [riib_pkg::SQ_W-1:0]       square_sum_red,
	output logic [riib_pkg::SQ_W-1:0]       square_sum_green,
	output logic [riib_pkg::SQ_W-1:0]       square_sum_blue,
	output logic                            row_end,
	output logic                            frame_end,
	input  logic                            cfg_we,
	input  logic [riib_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [riib_pkg::CFG_W-1:0]      cfg_data
);

	import riib_pkg::*;

	// configuration, kept as last column / last row index
	logic [COL_W-1:0] last_col_q;
	logic [ROW_W-1:0] last_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= COL_W'(WIDTH_RESET - 1);
			last_row_q <= ROW_W'(HEIGHT_RESET - 1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  last_col_q <= COL_W'(last_index(cfg_data, MAX_WIDTH));
				REG_IMAGE_HEIGHT: last_row_q <= ROW_W'(last_index(cfg_data, MAX_HEIGHT));
				default: ;
			endcase
		end
	end

	// accept stage: position counters and running row sums
	logic [COL_W-1:0]          col_q;
	logic [ROW_W-1:0]          row_q;
	logic [NCH-1:0][RS_W-1:0]  rs_q;
	logic [NCH-1:0][RSQ_W-1:0] rsq_q;

	logic                      in_xfer;
	logic                      pix_row_end;
	logic                      pix_frame_end;
	logic [NCH-1:0][PIX_W-1:0] pix;
	logic [NCH-1:0][PIX_SQ_W-1:0] pix_sq;
	logic [NCH-1:0][RS_W-1:0]  rs_new;
	logic [NCH-1:0][RSQ_W-1:0] rsq_new;

	s1_t     pipe_s1;
	logic    valid_s1;
	entry_t  fwd_s1;
	logic    s1_adv;
	entry_t  above;
	entry_t  res_entry;
	entry_t  ram_rdata;
	result_t out_q;
	logic    out_valid_q;

	assign pix[0] = red;
	assign pix[1] = green;
	assign pix[2] = blue;

	assign pix_row_end   = col_q >= last_col_q;
	assign pix_frame_end = pix_row_end && (row_q >= last_row_q);

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			pix_sq[c]  = PIX_SQ_W'(pix[c]) * PIX_SQ_W'(pix[c]);
			rs_new[c]  = rs_q[c] + RS_W'(pix[c]);
			rsq_new[c] = rsq_q[c] + RSQ_W'(pix_sq[c]);
		end
	end

	// stage 1 may move on when the result register is free or drains this cycle
	assign s1_adv   = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || s1_adv;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			rs_q  <= '0;
			rsq_q <= '0;
		end else if (in_xfer) begin
			if (pix_row_end) begin
				col_q <= '0;
				rs_q  <= '0;
				rsq_q <= '0;
				row_q <= pix_frame_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
				rs_q  <= rs_new;
				rsq_q <= rsq_new;
			end
		end
	end

	// stage 1: add the column above, write back, hand to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// a write of the same column lands at the read edge (one-pixel rows): forward it
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pipe_s1.col       <= col_q;
			pipe_s1.first_row <= row_q == '0;
			pipe_s1.row_end   <= pix_row_end;
			pipe_s1.frame_end <= pix_frame_end;
			pipe_s1.fwd       <= valid_s1 && (pipe_s1.col == col_q);
			pipe_s1.rs        <= rs_new;
			pipe_s1.rsq       <= rsq_new;
			fwd_s1            <= res_entry;
		end
	end

	always_comb begin
		if (pipe_s1.first_row) begin
			above = '0;
		end else if (pipe_s1.fwd) begin
			above = fwd_s1;
		end else begin
			above = ram_rdata;
		end
		for (int c = 0; c < NCH; c++) begin
			res_entry.sum[c] = SUM_W'(pipe_s1.rs[c]) + above.sum[c];
			res_entry.sq[c]  = SQ_W'(pipe_s1.rsq[c]) + above.sq[c];
		end
	end

	riib_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (valid_s1 && s1_adv),
		.waddr (pipe_s1.col),
		.wdata (res_entry),
		.re    (in_xfer),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_adv) begin
			out_q.data      <= res_entry;
			out_q.row_end   <= pipe_s1.row_end;
			out_q.frame_end <= pipe_s1.frame_end;
		end
	end

	assign out_valid        = out_valid_q;
	assign sum_red          = out_q.data.sum[0];
	assign sum_green        = out_q.data.sum[1];
	assign sum_blue         = out_q.data.sum[2];
	assign square_sum_red   = out_q.data.sq[0];
	assign square_sum_green = out_q.data.sq[1];
	assign square_sum_blue  = out_q.data.sq[2];
	assign row_end          = out_q.row_end;
	assign frame_end        = out_q.frame_end;

	// checks
	a_frame_end_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_q.frame_end || out_q.row_end))
		else $error("frame end without row end");

	a_fwd_on_same_column: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && valid_s1 && (pipe_s1.col == col_q)) |=> pipe_s1.fwd)
		else $error("same-column write-back not forwarded");

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("pixel input stalled without a full pipeline");

endmodule
